@@ hw/rtl/mlp_forward_pass_sigmoid_unit_assert.svh @@
// ----------------------------------------------------------------------------
// MLP forward pass unit assertion macros
// Concurrent assertion helpers clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef MLP_FORWARD_PASS_SIGMOID_UNIT_ASSERT_SVH
`define MLP_FORWARD_PASS_SIGMOID_UNIT_ASSERT_SVH

// same-cycle implication
`define MLPFS_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MLPFS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/mlpfs_pkg.sv @@
// ----------------------------------------------------------------------------
// mlpfs_pkg
// Shared types, codes and the sigmoid lookup table of the MLP forward pass unit.
// ----------------------------------------------------------------------------
package mlpfs_pkg;

  typedef enum logic [1:0] {
    CMD_WEIGHT = 2'd0,
    CMD_BIAS   = 2'd1,
    CMD_INPUT  = 2'd2,
    CMD_RUN    = 2'd3
  } cmd_e;

  localparam int VAL_W  = 16;
  localparam int PROD_W = 32;
  localparam int ACC_W  = 36;
  localparam int SIG_W  = 13;
  localparam int IDX_W  = 3;

  // parameter memory: weights at {0,sel,dest,src}, biases at {1,000,sel,dest}
  localparam int PRM_DEPTH = 144;
  localparam int PRM_AW    = 8;

  // value memory: {bank, index}
  localparam int VAL_DEPTH = 32;
  localparam int VAL_AW    = 5;
  localparam logic [1:0] BANK_IN = 2'd0;
  localparam logic [1:0] BANK_A  = 2'd1;
  localparam logic [1:0] BANK_B  = 2'd2;

  typedef struct packed {
    logic             v;
    logic             bias;
    logic             last;
    logic             zero;
    logic             vok;
    logic [IDX_W-1:0] dest;
  } mac_tok_t;

  typedef struct packed {
    logic             v;
    logic [IDX_W-1:0] idx;
    logic [SIG_W-1:0] value;
  } wr_req_t;

  typedef logic [255:0][SIG_W-1:0] sig_tab_t;

  function automatic sig_tab_t build_sig_table();
    sig_tab_t         tab;
    logic [63:0]      e;
    logic [63:0]      den;
    logic [63:0]      num;
    logic [63:0]      dsh;
    logic [SIG_W-1:0] sig;
    tab = '0;
    e   = 64'd1040706261;
    for (int k = 0; k < 128; k++) begin
      den = (64'd1 << 30) + e;
      num = (64'd1 << 42) + (den >> 1);
      sig = '0;
      for (int b = SIG_W - 1; b >= 0; b--) begin
        dsh = den << b;
        if (num >= dsh) begin
          num    = num - dsh;
          sig[b] = 1'b1;
        end
      end
      tab[8'(128 + k)] = sig;
      tab[8'(127 - k)] = 13'd4096 - sig;
      e = (e * 64'd1008687096 + (64'd1 << 29)) >> 30;
    end
    return tab;
  endfunction

  localparam sig_tab_t SIG_TABLE = build_sig_table();

endpackage

@@ hw/rtl/mlp_forward_pass_sigmoid_unit.sv @@
// ----------------------------------------------------------------------------
// mlp_forward_pass_sigmoid_unit
// Weight, bias and input writes leave the unit idle; the next transaction is taken at once.
// A run steps through every layer: for each destination node, a bias step and then
// one parameter-memory read per multiply-accumulate, after which the results are
// emitted. One item is processed at a time.
// Reset clears control and input valid bits; weights and biases need writing.
// ----------------------------------------------------------------------------
module mlp_forward_pass_sigmoid_unit #(
  parameter int INPUT_NODES   = 4,
  parameter int HIDDEN_NODES  = 8,
  parameter int OUTPUT_NODES  = 4,
  parameter int HIDDEN_LAYERS = 1,
  parameter int MAX_WIDTH     = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // dest_index[2:0], source_index[5:3], data_value[21:6]
  input  logic [2:0]  s_axis_tuser,  // command[1:0], layer_select[2]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // out_index[1:0], out_value[14:2]
  output logic        m_axis_tlast
);
  import mlpfs_pkg::*;

  localparam int IN_W   = INPUT_NODES  < MAX_WIDTH ? INPUT_NODES  : MAX_WIDTH;
  localparam int HID_W  = HIDDEN_NODES < MAX_WIDTH ? HIDDEN_NODES : MAX_WIDTH;
  localparam int OUT_W  = OUTPUT_NODES < MAX_WIDTH ? OUTPUT_NODES : MAX_WIDTH;
  localparam int NTRANS = HIDDEN_LAYERS + 1;
  localparam int EMIT_N = OUT_W < 4 ? OUT_W : 4;
  localparam int TW     = $clog2(NTRANS);
  localparam logic [TW-1:0] LAST_T  = TW'(NTRANS - 1);
  localparam logic [3:0]    IN_N    = 4'(IN_W);
  localparam logic [3:0]    HID_N   = 4'(HID_W);
  localparam logic [3:0]    OUT_N   = 4'(OUT_W);
  localparam logic [1:0]    EMIT_LST = 2'(EMIT_N - 1);
  localparam logic [1:0]    OUT_BANK = ((NTRANS - 1) % 2 == 1) ? BANK_B : BANK_A;

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_BIAS    = 3'd1;
  localparam logic [2:0] ST_MAC     = 3'd2;
  localparam logic [2:0] ST_DRAIN   = 3'd3;
  localparam logic [2:0] ST_EMIT_RD = 3'd4;
  localparam logic [2:0] ST_EMIT_LD = 3'd5;

  logic [2:0]       state_q, state_d;
  logic [TW-1:0]    trans_q, trans_d;
  logic [IDX_W-1:0] dest_q, dest_d, src_q, src_d;
  logic [1:0]       emit_q, emit_d;
  logic [7:0]       in_valid_q, in_valid_d;
  logic             out_valid_q, out_valid_d;
  logic [1:0]       out_idx_q, out_idx_d;
  logic [SIG_W-1:0] out_val_q, out_val_d;
  logic             out_last_q, out_last_d;

  cmd_e             cmd;
  logic             lsel;
  logic [IDX_W-1:0] in_dest, in_src;
  logic [VAL_W-1:0] in_val;
  logic             s_fire, m_fire, load_out;
  logic             d_ok, s_ok, in_ok;
  logic             t_first, t_last;
  logic [3:0]       src_n, dst_n;
  logic             src_end, dst_end;
  logic [1:0]       src_bank, dest_bank;

  logic              p_we;
  logic [PRM_AW-1:0] p_waddr, p_raddr;
  logic [VAL_W-1:0]  p_rdata;
  logic              v_we;
  logic [VAL_AW-1:0] v_waddr, v_raddr;
  logic [VAL_W-1:0]  v_wdata, v_rdata;

  mac_tok_t tok;
  wr_req_t  wr;
  logic     mac_busy;

  assign cmd     = cmd_e'(s_axis_tuser[1:0]);
  assign lsel    = s_axis_tuser[2];
  assign in_dest = s_axis_tdata[2:0];
  assign in_src  = s_axis_tdata[5:3];
  assign in_val  = s_axis_tdata[21:6];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign m_fire        = m_axis_tvalid && m_axis_tready;

  assign d_ok  = lsel ? ({1'b0, in_dest} < OUT_N) : ({1'b0, in_dest} < HID_N);
  assign s_ok  = lsel ? ({1'b0, in_src} < HID_N) : ({1'b0, in_src} < IN_N);
  assign in_ok = {1'b0, in_dest} < IN_N;

  assign t_first   = (trans_q == '0);
  assign t_last    = (trans_q == LAST_T);
  assign src_n     = t_first ? IN_N : HID_N;
  assign dst_n     = t_last ? OUT_N : HID_N;
  assign src_end   = (src_q == 3'(src_n - 4'd1));
  assign dst_end   = (dest_q == 3'(dst_n - 4'd1));
  assign src_bank  = t_first ? BANK_IN : (trans_q[0] ? BANK_A : BANK_B);
  assign dest_bank = trans_q[0] ? BANK_B : BANK_A;

  // parameter memory
  always_comb begin
    p_we    = s_fire && ((cmd == CMD_WEIGHT && d_ok && s_ok) || (cmd == CMD_BIAS && d_ok));
    p_waddr = (cmd == CMD_BIAS) ? {1'b1, 3'b000, lsel, in_dest} : {1'b0, lsel, in_dest, in_src};
    p_raddr = (state_q == ST_BIAS) ? {1'b1, 3'b000, t_last, dest_q}
                                   : {1'b0, t_last, dest_q, src_q};
  end

  // value memory
  always_comb begin
    if (wr.v) begin
      v_we    = 1'b1;
      v_waddr = {dest_bank, wr.idx};
      v_wdata = {3'b000, wr.value};
    end else begin
      v_we    = s_fire && cmd == CMD_INPUT && in_ok;
      v_waddr = {BANK_IN, in_dest};
      v_wdata = in_val;
    end
    if (state_q == ST_EMIT_RD || state_q == ST_EMIT_LD) begin
      v_raddr = {OUT_BANK, 1'b0, emit_q};
    end else begin
      v_raddr = {src_bank, src_q};
    end
  end

  always_comb begin
    tok.v    = (state_q == ST_BIAS) || (state_q == ST_MAC);
    tok.bias = (state_q == ST_BIAS);
    tok.last = (state_q == ST_MAC) && src_end;
    tok.zero = !t_first && !t_last;
    tok.vok  = !t_first || in_valid_q[src_q];
    tok.dest = dest_q;
  end

  mlpfs_ram #(.WIDTH(VAL_W), .DEPTH(PRM_DEPTH)) u_prm_ram (
    .clk_i   (clk_i),
    .we_i    (p_we),
    .waddr_i (p_waddr),
    .wdata_i (in_val),
    .raddr_i (p_raddr),
    .rdata_o (p_rdata)
  );

  mlpfs_ram #(.WIDTH(VAL_W), .DEPTH(VAL_DEPTH)) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (v_we),
    .waddr_i (v_waddr),
    .wdata_i (v_wdata),
    .raddr_i (v_raddr),
    .rdata_o (v_rdata)
  );

  mlpfs_mac u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .tok_i   (tok),
    .vdata_i (v_rdata),
    .pdata_i (p_rdata),
    .wr_o    (wr),
    .busy_o  (mac_busy)
  );

  assign load_out = (state_q == ST_EMIT_LD) && (!out_valid_q || m_axis_tready);

  always_comb begin
    state_d     = state_q;
    trans_d     = trans_q;
    dest_d      = dest_q;
    src_d       = src_q;
    emit_d      = emit_q;
    in_valid_d  = in_valid_q;
    out_valid_d = out_valid_q;
    out_idx_d   = out_idx_q;
    out_val_d   = out_val_q;
    out_last_d  = out_last_q;

    if (m_fire) begin
      out_valid_d = 1'b0;
    end
    if (load_out) begin
      out_valid_d = 1'b1;
      out_idx_d   = emit_q;
      out_val_d   = v_rdata[SIG_W-1:0];
      out_last_d  = (emit_q == EMIT_LST);
    end
    if (s_fire && cmd == CMD_INPUT && in_ok) begin
      in_valid_d[in_dest] = 1'b1;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (s_fire && cmd == CMD_RUN) begin
          trans_d = '0;
          dest_d  = '0;
          src_d   = '0;
          state_d = ST_BIAS;
        end
      end
      ST_BIAS: begin
        src_d   = '0;
        state_d = ST_MAC;
      end
      ST_MAC: begin
        if (src_end) begin
          if (dst_end) begin
            state_d = ST_DRAIN;
          end else begin
            dest_d  = dest_q + 3'd1;
            state_d = ST_BIAS;
          end
        end else begin
          src_d = src_q + 3'd1;
        end
      end
      ST_DRAIN: begin
        if (!mac_busy) begin
          if (t_last) begin
            emit_d  = '0;
            state_d = ST_EMIT_RD;
          end else begin
            trans_d = trans_q + TW'(1);
            dest_d  = '0;
            state_d = ST_BIAS;
          end
        end
      end
      ST_EMIT_RD: begin
        state_d = ST_EMIT_LD;
      end
      ST_EMIT_LD: begin
        if (load_out) begin
          if (emit_q == EMIT_LST) begin
            state_d = ST_IDLE;
          end else begin
            emit_d  = emit_q + 2'd1;
            state_d = ST_EMIT_RD;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      trans_q     <= '0;
      dest_q      <= '0;
      src_q       <= '0;
      emit_q      <= '0;
      in_valid_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      trans_q     <= trans_d;
      dest_q      <= dest_d;
      src_q       <= src_d;
      emit_q      <= emit_d;
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_idx_q  <= out_idx_d;
    out_val_q  <= out_val_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_val_q, out_idx_q};
  assign m_axis_tlast  = out_last_q;

endmodule

@@ hw/rtl/mlpfs_ram.sv @@
// ----------------------------------------------------------------------------
// mlpfs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mlpfs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ hw/rtl/mlpfs_mac.sv @@
// ----------------------------------------------------------------------------
// mlpfs_mac
// Multiply-accumulate pipeline: operand select and multiply, accumulate,
// round and saturate to Q4.12, sigmoid lookup and node write-back request.
// ----------------------------------------------------------------------------
module mlpfs_mac (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  mlpfs_pkg::mac_tok_t     tok_i,
  input  logic [mlpfs_pkg::VAL_W-1:0] vdata_i,
  input  logic [mlpfs_pkg::VAL_W-1:0] pdata_i,
  output mlpfs_pkg::wr_req_t      wr_o,
  output logic                    busy_o
);
  import mlpfs_pkg::*;

  mac_tok_t p1_q, p2_q, p3_q, p4_q;
  mac_tok_t p3_d;
  logic signed [VAL_W-1:0]  op_a, op_b;
  logic signed [PROD_W-1:0] prod_d, prod_q;
  logic signed [ACC_W-1:0]  acc_d, acc_q, rnd;
  logic signed [ACC_W-13:0] shq;
  logic [VAL_W-1:0]         sat;
  logic [7:0]               idx_d, idx_q;

  // stage 1: memory data arrives, multiply
  always_comb begin
    op_a   = p1_q.bias ? 16'sd4096 : (p1_q.vok ? signed'(vdata_i) : '0);
    op_b   = p1_q.zero ? '0 : signed'(pdata_i);
    prod_d = op_a * op_b;
  end

  // stage 2: accumulate
  always_comb begin
    acc_d = acc_q;
    if (p2_q.v) begin
      acc_d = p2_q.bias ? ACC_W'(prod_q) : acc_q + ACC_W'(prod_q);
    end
  end

  // only the final product of a node moves on to rounding
  always_comb begin
    p3_d   = p2_q;
    p3_d.v = p2_q.v && p2_q.last;
  end

  // stage 3: round half up, saturate, table index
  always_comb begin
    rnd = acc_q + ACC_W'(2048);
    shq = rnd[ACC_W-1:12];
    if (shq > 24'sd32767) begin
      sat = 16'h7FFF;
    end else if (shq < -24'sd32768) begin
      sat = 16'h8000;
    end else begin
      sat = shq[VAL_W-1:0];
    end
    idx_d = {~sat[15], sat[14:8]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_q <= '0;
      p2_q <= '0;
      p3_q <= '0;
      p4_q <= '0;
    end else begin
      p1_q <= tok_i;
      p2_q <= p1_q;
      p3_q <= p3_d;
      p4_q <= p3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    acc_q  <= acc_d;
    idx_q  <= idx_d;
  end

  // stage 4: sigmoid lookup, write-back
  assign wr_o.v     = p4_q.v;
  assign wr_o.idx   = p4_q.dest;
  assign wr_o.value = SIG_TABLE[idx_q];
  assign busy_o     = p1_q.v | p2_q.v | p3_q.v | p4_q.v;

endmodule

@@ hw/rtl/mlpfs_check.sv @@
// ----------------------------------------------------------------------------
// mlpfs_check
// Port-level checks of the MLP forward pass unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "mlp_forward_pass_sigmoid_unit_assert.svh"

module mlpfs_check #(
  parameter int OUTPUT_NODES = 4,
  parameter int MAX_WIDTH    = 8
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [2:0]  s_axis_tuser,  // command[1:0], layer_select[2]
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,  // out_index[1:0], out_value[14:2]
  input logic        m_axis_tlast
);
  import mlpfs_pkg::*;

  localparam int OUT_W  = OUTPUT_NODES < MAX_WIDTH ? OUTPUT_NODES : MAX_WIDTH;
  localparam int EMIT_N = OUT_W < 4 ? OUT_W : 4;
  localparam logic [1:0] EMIT_LST = 2'(EMIT_N - 1);

  logic s_fire;
  logic is_run;

  assign s_fire = s_axis_tvalid && s_axis_tready;
  assign is_run = (s_axis_tuser[1:0] == CMD_RUN);

  `MLPFS_ASSERT_NEXT(a_write_keeps_ready, s_fire && !is_run, s_axis_tready,
    "write transaction left the input stalled")
  `MLPFS_ASSERT_NEXT(a_run_blocks_input, s_fire && is_run, !s_axis_tready,
    "input accepted while a run is in progress")
  `MLPFS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast),
    "stalled output transaction changed")
  `MLPFS_ASSERT_SAME(a_last_index, m_axis_tvalid,
    m_axis_tlast == (m_axis_tdata[1:0] == EMIT_LST),
    "last flag does not match final output node")

endmodule

bind mlp_forward_pass_sigmoid_unit mlpfs_check #(
  .OUTPUT_NODES (OUTPUT_NODES),
  .MAX_WIDTH    (MAX_WIDTH)
) u_mlpfs_check (.*);
